// File: rtl/core/agasf_pkg.sv
// ----------------------------------------------------------------------------
// agasf_pkg: shared types and helpers for the affine-gap score fill
// word types, register indexes and saturating arithmetic
// ----------------------------------------------------------------------------
package agasf_pkg;

  localparam int MaxColumns = 1024;
  localparam int ColW       = $clog2(MaxColumns);
  localparam int MaxRows    = 65535;
  localparam int RowW       = 16;
  localparam int CfgIdxW    = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_GAP_OPEN_A   = 3'd0,
    REG_GAP_EXTEND_A = 3'd1,
    REG_GAP_OPEN_B   = 3'd2,
    REG_GAP_EXTEND_B = 3'd3,
    REG_EXT_ON_OPEN  = 3'd4,
    REG_END_GAP_ON   = 3'd5,
    REG_GLOBAL_MODE  = 3'd6,
    REG_ROW_LENGTH   = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic signed [23:0] match_score;
    logic               last_cell;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] cell_score;
    logic               best_from_diagonal;
    logic               best_from_gap_a;
    logic               best_from_gap_b;
    logic               end_of_matrix;
  } out_word_t;

  // classified cell as handed from front to back
  typedef struct packed {
    logic signed [23:0] match_score;
    logic               last_cell;
    logic [ColW-1:0]    col;
    logic               row_zero;
    logic               col_zero;
    logic               col_gt1;
    logic               row_gt1;
  } cell_t;

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] s;
    s = 33'(a) + 33'(b);
    if (s > 33'sd2147483647)       sat_add = 32'sh7fffffff;
    else if (s < -33'sd2147483648) sat_add = 32'sh80000000;
    else                           sat_add = s[31:0];
  endfunction

  function automatic logic signed [31:0] max2(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    max2 = (b > a) ? b : a;
  endfunction

endpackage

// File: rtl/core/agasf_front.sv
// ----------------------------------------------------------------------------
// agasf_front: cell position tracking
// accepts score words and tags each with its row/column class
// ----------------------------------------------------------------------------
module agasf_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [10:0]         row_length_i,
  input  logic                in_valid,
  output logic                in_stall,
  input  agasf_pkg::in_word_t in_data,
  output logic                q_valid_o,
  input  logic                q_full_i,
  output agasf_pkg::cell_t    q_data_o
);
  logic [agasf_pkg::RowW-1:0] row_q, row_d;
  logic [agasf_pkg::ColW-1:0] col_q, col_d;
  logic [10:0]                len;
  logic                       acc;

  assign in_stall = q_full_i;
  assign acc      = in_valid & ~q_full_i;
  assign q_valid_o = acc;

  always_comb begin
    if (row_length_i == 11'd0) len = 11'd1;
    else if (row_length_i > 11'(agasf_pkg::MaxColumns)) len = 11'(agasf_pkg::MaxColumns);
    else len = row_length_i;
  end

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (in_data.last_cell) begin
      row_d = '0;
      col_d = '0;
    end else if (11'(col_q) + 11'd1 >= len) begin
      col_d = '0;
      if (row_q != agasf_pkg::RowW'(agasf_pkg::MaxRows - 1)) row_d = row_q + 1'b1;
    end else begin
      col_d = col_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (acc) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  always_comb begin
    q_data_o.match_score = in_data.match_score;
    q_data_o.last_cell   = in_data.last_cell;
    q_data_o.col         = col_q;
    q_data_o.row_zero    = (row_q == '0);
    q_data_o.col_zero    = (col_q == '0);
    q_data_o.col_gt1     = (col_q > agasf_pkg::ColW'(1));
    q_data_o.row_gt1     = (row_q > agasf_pkg::RowW'(1));
  end
endmodule

// File: rtl/core/agasf_queue.sv
// ----------------------------------------------------------------------------
// agasf_queue: two-entry cell queue
// decouples the position tracker from the score datapath
// ----------------------------------------------------------------------------
module agasf_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  agasf_pkg::cell_t push_data_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output agasf_pkg::cell_t data_o
);
  agasf_pkg::cell_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end
endmodule

// File: rtl/core/agasf_back.sv
// ----------------------------------------------------------------------------
// agasf_back: score datapath
// two-stage cell scoring with previous-row score and column-gap memories
// ----------------------------------------------------------------------------
module agasf_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic signed [23:0]       gap_open_a_i,
  input  logic signed [23:0]       gap_extend_a_i,
  input  logic signed [23:0]       gap_open_b_i,
  input  logic signed [23:0]       gap_extend_b_i,
  input  logic                     extend_on_open_i,
  input  logic                     end_gap_on_i,
  input  logic                     global_mode_i,
  input  logic                     q_valid_i,
  output logic                     q_pop_o,
  input  agasf_pkg::cell_t         q_data_i,
  output logic                     out_valid,
  input  logic                     out_stall,
  output agasf_pkg::out_word_t     out_data
);
  localparam int CW = agasf_pkg::ColW;

  // stage 1 holds the cell while the memories are read
  logic             s1_valid_q;
  agasf_pkg::cell_t s1_q;
  logic             adv1, adv2;

  logic signed [31:0] prev_mem [agasf_pkg::MaxColumns];
  logic signed [31:0] gapb_mem [agasf_pkg::MaxColumns];
  logic signed [31:0] above_rd_q, gb_rd_q;

  // bypass of the column written by the cell just finished
  logic signed [31:0] wb_pdat_q, wb_gdat_q;

  logic signed [31:0] row_gap_q, row_gap_d, diag_q, diag_d;
  logic signed [31:0] row_pen_q, row_pen_d, col_pen_q, col_pen_d;

  logic signed [31:0] ext_a, ext_b, first_a, first_b, above, gb, pen, best, score, sc2;
  logic               fd, fa, fb;
  logic               pwe, gwe;
  logic [CW-1:0]      pcol, gcol, rd_gcol;
  logic signed [31:0] pdat, gdat;

  assign adv2    = s1_valid_q & (~out_valid | ~out_stall);
  assign adv1    = ~s1_valid_q | adv2;
  assign q_pop_o = q_valid_i & adv1;
  assign rd_gcol = (q_data_i.col == '0) ? '0 : q_data_i.col - 1'b1;

  assign ext_a   = 32'(gap_extend_a_i);
  assign ext_b   = 32'(gap_extend_b_i);
  assign first_a = extend_on_open_i ? agasf_pkg::sat_add(32'(gap_open_a_i), ext_a)
                                    : 32'(gap_open_a_i);
  assign first_b = extend_on_open_i ? agasf_pkg::sat_add(32'(gap_open_b_i), ext_b)
                                    : 32'(gap_open_b_i);

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      above_rd_q <= prev_mem[q_data_i.col];
      gb_rd_q    <= gapb_mem[rd_gcol];
      s1_q       <= q_data_i;
    end
    if (adv2 && pwe) prev_mem[pcol] <= pdat;
    if (adv2 && gwe) gapb_mem[gcol] <= gdat;
    if (adv2) begin
      wb_pdat_q <= pdat;
      wb_gdat_q <= gdat;
    end
  end

  // read happened while previous cell's write was in flight: forward it
  logic fwd_p, fwd_g;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_p      <= 1'b0;
      fwd_g      <= 1'b0;
    end else begin
      if (adv1) s1_valid_q <= q_pop_o;
      if (q_pop_o) begin
        fwd_p <= adv2 & pwe & (pcol == q_data_i.col);
        fwd_g <= adv2 & gwe & (gcol == rd_gcol);
      end else if (adv2) begin
        fwd_p <= 1'b0;
        fwd_g <= 1'b0;
      end
    end
  end

  assign above = fwd_p ? wb_pdat_q : above_rd_q;
  assign gb    = fwd_g ? wb_gdat_q : gb_rd_q;

  always_comb begin
    row_gap_d = row_gap_q; diag_d = diag_q;
    row_pen_d = row_pen_q; col_pen_d = col_pen_q;
    fd = 1'b0; fa = 1'b0; fb = 1'b0;
    pwe = 1'b1; pcol = s1_q.col; gwe = 1'b0; gcol = s1_q.col;
    gdat = '0; best = diag_q; pen = '0; sc2 = '0;
    if (s1_q.row_zero) begin
      pen       = s1_q.col_zero ? '0 : row_pen_q;
      row_pen_d = s1_q.col_zero ? first_a : agasf_pkg::sat_add(pen, ext_a);
      if (s1_q.col_zero) col_pen_d = first_b;
      score = end_gap_on_i ? agasf_pkg::sat_add(32'(s1_q.match_score), pen)
                           : 32'(s1_q.match_score);
      gwe  = 1'b1;
      gdat = agasf_pkg::sat_add(score, first_b);
    end else if (s1_q.col_zero) begin
      pen       = col_pen_q;
      col_pen_d = agasf_pkg::sat_add(pen, ext_b);
      score = end_gap_on_i ? agasf_pkg::sat_add(32'(s1_q.match_score), pen)
                           : 32'(s1_q.match_score);
      row_gap_d = agasf_pkg::sat_add(above, first_a);
      diag_d    = above;
    end else begin
      if (s1_q.col_gt1 && row_gap_q > best) best = row_gap_q;
      if (s1_q.row_gt1 && gb > best) best = gb;
      fd = (diag_q == best);
      fa = s1_q.col_gt1 && (row_gap_q == best);
      fb = s1_q.row_gt1 && (gb == best);
      gwe  = 1'b1;
      gcol = s1_q.col - 1'b1;
      gdat = agasf_pkg::max2(agasf_pkg::sat_add(diag_q, first_b),
                             agasf_pkg::sat_add(gb, ext_b));
      row_gap_d = agasf_pkg::max2(agasf_pkg::sat_add(diag_q, first_a),
                                  agasf_pkg::sat_add(row_gap_q, ext_a));
      sc2   = agasf_pkg::sat_add(best, 32'(s1_q.match_score));
      score = (!global_mode_i && sc2 < 0) ? '0 : sc2;
      diag_d = above;
    end
    pdat = score;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_gap_q <= '0; diag_q <= '0; row_pen_q <= '0; col_pen_q <= '0;
      out_valid <= 1'b0;
    end else begin
      if (adv2) begin
        row_gap_q <= row_gap_d; diag_q <= diag_d;
        row_pen_q <= row_pen_d; col_pen_q <= col_pen_d;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      out_data.cell_score         <= pdat;
      out_data.best_from_diagonal <= fd;
      out_data.best_from_gap_a    <= fa;
      out_data.best_from_gap_b    <= fb;
      out_data.end_of_matrix      <= s1_q.last_cell;
    end
  end
endmodule

// File: rtl/core/affine_gap_alignment_score_fill.sv
// ----------------------------------------------------------------------------
// affine_gap_alignment_score_fill: streaming affine-gap score matrix fill
// one score word per cell in, one scored cell word out
// ----------------------------------------------------------------------------
// path: an accepted input word enters a queue slot, then the memory read stage,
//   then the output register that drives out_valid and out_data
// throughput: one cell per cycle while out_stall is low, with the read-modify-write
//   of the previous-row and column-gap memories forwarded on back-to-back use
// reset: registers take their documented values, indices and gap state clear;
//   the row memories are not cleared and are written by row 0 before use
module affine_gap_alignment_score_fill (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  agasf_pkg::in_word_t         in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output agasf_pkg::out_word_t        out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [agasf_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [31:0]                 cfg_data
);
  // configuration registers
  logic signed [23:0] gap_open_a_q, gap_extend_a_q, gap_open_b_q, gap_extend_b_q;
  logic               ext_on_open_q, end_gap_on_q, global_mode_q;
  logic [10:0]        row_length_q;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_open_a_q   <= -24'sd10000;
      gap_extend_a_q <= -24'sd1000;
      gap_open_b_q   <= -24'sd10000;
      gap_extend_b_q <= -24'sd1000;
      ext_on_open_q  <= 1'b1;
      end_gap_on_q   <= 1'b0;
      global_mode_q  <= 1'b1;
      row_length_q   <= 11'd1024;
    end else if (cfg_valid) begin
      case (agasf_pkg::cfg_reg_e'(cfg_index))
        agasf_pkg::REG_GAP_OPEN_A:   gap_open_a_q   <= cfg_data[23:0];
        agasf_pkg::REG_GAP_EXTEND_A: gap_extend_a_q <= cfg_data[23:0];
        agasf_pkg::REG_GAP_OPEN_B:   gap_open_b_q   <= cfg_data[23:0];
        agasf_pkg::REG_GAP_EXTEND_B: gap_extend_b_q <= cfg_data[23:0];
        agasf_pkg::REG_EXT_ON_OPEN:  ext_on_open_q  <= cfg_data[0];
        agasf_pkg::REG_END_GAP_ON:   end_gap_on_q   <= cfg_data[0];
        agasf_pkg::REG_GLOBAL_MODE:  global_mode_q  <= cfg_data[0];
        agasf_pkg::REG_ROW_LENGTH:   row_length_q   <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // front -> queue -> back
  logic             push, q_full, q_valid, q_pop;
  agasf_pkg::cell_t push_data, q_data;

  agasf_front u_front (
    .clk_i, .rst_ni,
    .row_length_i (row_length_q),
    .in_valid, .in_stall, .in_data,
    .q_valid_o (push), .q_full_i (q_full), .q_data_o (push_data)
  );

  agasf_queue u_queue (
    .clk_i, .rst_ni,
    .push_i (push), .push_data_i (push_data), .full_o (q_full),
    .valid_o (q_valid), .pop_i (q_pop), .data_o (q_data)
  );

  agasf_back u_back (
    .clk_i, .rst_ni,
    .gap_open_a_i (gap_open_a_q), .gap_extend_a_i (gap_extend_a_q),
    .gap_open_b_i (gap_open_b_q), .gap_extend_b_i (gap_extend_b_q),
    .extend_on_open_i (ext_on_open_q), .end_gap_on_i (end_gap_on_q),
    .global_mode_i (global_mode_q),
    .q_valid_i (q_valid), .q_pop_o (q_pop), .q_data_i (q_data),
    .out_valid, .out_stall, .out_data
  );
endmodule
